[src/mm64_pkg.sv]
`default_nettype none

package mm64_pkg;

	// Multiplier and shift of the 64-bit Murmur mixing function.
	localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
	localparam int          MIX_SHIFT = 47;

	// Input queue between the front and the back.
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Configuration port: one 64-bit register at byte address 0.
	localparam int   REG_ADDR_W        = 4;
	localparam logic REG_IDX_HASH_SEED = 1'b0;

	// What an item asks of the back.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_PART = 2'd1,
		KIND_FULL = 2'd2
	} kind_t;

	typedef struct packed {
		logic [63:0] word;
		logic [31:0] length;
		kind_t       kind;
		logic        first;
		logic        last;
	} op_t;

	function automatic logic [63:0] mix_shift(input logic [63:0] x);
		return x ^ (x >> MIX_SHIFT);
	endfunction

endpackage

`default_nettype wire

[src/mm64_front.sv]
`default_nettype none

// Takes input items, tracks message boundaries and classifies each word.
module mm64_front import mm64_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        last,
	input  wire logic [31:0] message_length,
	input  wire logic        full,
	output logic             push,
	output op_t              push_op
);

	logic        in_msg_q;
	logic [63:0] lane_mask;

	assign in_stall = full;
	assign push     = in_valid && !full;

	// Byte counts of eight and above keep every lane.
	always_comb begin
		lane_mask = '0;
		for (int i = 0; i < 8; i++) begin
			if (byte_count > 4'(i)) begin
				lane_mask[8*i +: 8] = 8'hff;
			end
		end
	end

	always_comb begin
		push_op.length = message_length;
		push_op.first  = !in_msg_q;
		push_op.last   = last;
		push_op.word   = data_word & lane_mask;
		if (byte_count == 4'd0) begin
			push_op.kind = KIND_NONE;
		end else if (byte_count[3]) begin
			push_op.kind = KIND_FULL;
		end else begin
			push_op.kind = KIND_PART;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
		end else if (push) begin
			in_msg_q <= !last;
		end
	end

endmodule

`default_nettype wire

[src/mm64_fifo.sv]
`default_nettype none

// Short queue of classified items between the front and the back.
module mm64_fifo import mm64_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output op_t       pop_op,
	output logic      empty
);

	op_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

[src/mm64_mul.sv]
`default_nettype none

// Low 64 bits of a times the mixing constant, one 32x32 product per cycle.
module mm64_mul import mm64_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] a,
	output logic             busy,
	output logic             done,
	output logic [63:0]      prod
);

	localparam logic [1:0] STEP_LO_LO = 2'd0;
	localparam logic [1:0] STEP_LO_HI = 2'd1;
	localparam logic [1:0] STEP_HI_LO = 2'd2;

	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] part;

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

	always_comb begin
		op_a = (step_q == STEP_HI_LO) ? a_q[63:32] : a_q[31:0];
		op_b = (step_q == STEP_LO_HI) ? MIX_MUL[63:32] : MIX_MUL[31:0];
		part = op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_LO_LO;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= STEP_LO_LO;
			end else if (busy_q) begin
				if (step_q == STEP_HI_LO) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// The cross products only reach the upper half of the result.
	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
		end else if (busy_q) begin
			if (step_q == STEP_LO_LO) begin
				acc_q <= part;
			end else begin
				acc_q <= {acc_q[63:32] + part[31:0], acc_q[31:0]};
			end
		end
	end

endmodule

`default_nettype wire

[src/mm64_back.sv]
`default_nettype none

// Runs the hash steps of each queued item on the shared multiplier.
module mm64_back import mm64_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire op_t         pop_op,
	output logic             pop,
	input  wire logic [63:0] hash_seed,
	output logic             mul_go,
	output logic [63:0]      mul_a,
	input  wire logic        mul_busy,
	input  wire logic        mul_done,
	input  wire logic [63:0] mul_prod,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      hash_value
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SEED  = 7'b0000010,
		S_KMUL1 = 7'b0000100,
		S_KMUL2 = 7'b0001000,
		S_HMUL  = 7'b0010000,
		S_FMUL  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t      state_q, state_d;
	op_t         op_q;
	logic [63:0] h_q, h_d;
	logic [63:0] k_q, k_d;
	logic        pend_q;
	logic        out_valid_q, out_valid_d;
	logic [63:0] out_hash_q;
	logic        out_load;
	logic        mul_state;
	op_t         op_cur;
	logic [63:0] h_base;
	logic [63:0] h_start;
	state_t      st_start;

	assign out_valid  = out_valid_q;
	assign hash_value = out_hash_q;
	assign pop        = (state_q == S_IDLE) && !empty;

	assign mul_state = (state_q == S_SEED) || (state_q == S_KMUL1) || (state_q == S_KMUL2) ||
		(state_q == S_HMUL) || (state_q == S_FMUL);
	assign mul_go = mul_state && !pend_q;

	always_comb begin
		case (state_q)
			S_SEED:  mul_a = {32'd0, op_q.length};
			S_KMUL1: mul_a = op_q.word;
			S_KMUL2: mul_a = k_q;
			S_HMUL:  mul_a = h_q;
			S_FMUL:  mul_a = h_q;
			default: mul_a = '0;
		endcase
	end

	// Where an item goes once its starting hash is known.
	always_comb begin
		op_cur = (state_q == S_IDLE) ? pop_op : op_q;
		h_base = (state_q == S_SEED) ? (hash_seed ^ mul_prod) : h_q;
		case (op_cur.kind)
			KIND_FULL: begin
				h_start  = h_base;
				st_start = S_KMUL1;
			end
			KIND_PART: begin
				h_start  = h_base ^ op_cur.word;
				st_start = S_HMUL;
			end
			default: begin
				if (op_cur.last) begin
					h_start  = mix_shift(h_base);
					st_start = S_FMUL;
				end else begin
					h_start  = h_base;
					st_start = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		h_d         = h_q;
		k_d         = k_q;
		out_load    = 1'b0;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					if (pop_op.first) begin
						state_d = S_SEED;
					end else begin
						state_d = st_start;
						h_d     = h_start;
					end
				end
			end
			S_SEED: begin
				if (mul_done) begin
					state_d = st_start;
					h_d     = h_start;
				end
			end
			S_KMUL1: begin
				if (mul_done) begin
					k_d     = mix_shift(mul_prod);
					state_d = S_KMUL2;
				end
			end
			S_KMUL2: begin
				if (mul_done) begin
					h_d     = h_q ^ mul_prod;
					state_d = S_HMUL;
				end
			end
			S_HMUL: begin
				if (mul_done) begin
					if (op_q.last) begin
						h_d     = mix_shift(mul_prod);
						state_d = S_FMUL;
					end else begin
						h_d     = mul_prod;
						state_d = S_IDLE;
					end
				end
			end
			S_FMUL: begin
				if (mul_done) begin
					k_d     = mix_shift(mul_prod);
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			if (mul_go) begin
				pend_q <= 1'b1;
			end else if (mul_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		h_q <= h_d;
		k_q <= k_d;
		if (pop) begin
			op_q <= pop_op;
		end
		if (out_load) begin
			out_hash_q <= k_q;
		end
	end

	a_go_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go |-> !mul_busy)
		else $error("multiplier started while busy");

	a_done_was_asked: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> pend_q)
		else $error("product arrived with no request outstanding");

	a_pop_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != S_IDLE) || ($past(pop_op.kind) == KIND_NONE))
		else $error("item taken from the queue but not worked on");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("output overwritten while held");

endmodule

`default_nettype wire

[src/murmur64a_hash_stream_core.sv]
`default_nettype none

// MurmurHash64A stream core. A message arrives as little-endian 8-byte items
// on data_word, byte_count giving the valid low bytes and last marking the
// final item; message_length is read on the first item of each message and
// seeds the hash as hash_seed xor (length times the mixing constant). An
// empty message is a single item with byte_count zero and last set. One hash
// leaves on hash_value for each message, after its last item. Items pass a
// two-entry queue into a sequencer that does every 64-bit multiply on one
// shared 32x32 multiplier, three partial products per multiply, so the
// multiplier sets the rate: a full word takes three multiplies, a partial
// word one and an empty item none, plus one multiply for the seed on a
// first item and one for finalization on a last item. The hash_seed
// register sits at byte address 0 of the APB port; write it only while no
// message is in progress.
module murmur64a_hash_stream_core import mm64_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [63:0]           pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	// Input items.
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [63:0]           data_word,
	input  wire logic [3:0]            byte_count,
	input  wire logic                  last,
	input  wire logic [31:0]           message_length,
	// Result items.
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [63:0]                hash_value
);

	logic [63:0] seed_q;
	logic        seed_sel;
	logic        push;
	op_t         push_op;
	logic        full;
	logic        pop;
	op_t         pop_op;
	logic        empty;
	logic        mul_go;
	logic [63:0] mul_a;
	logic        mul_busy;
	logic        mul_done;
	logic [63:0] mul_prod;

	// The register index is the address bit above the 8-byte offset.
	assign seed_sel = (paddr[REG_ADDR_W-1] == REG_IDX_HASH_SEED);
	assign pready   = 1'b1;
	assign prdata   = seed_sel ? seed_q : 64'd0;

	// The seed resets to zero and is written in the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite && pready && seed_sel) begin
			seed_q <= pwdata;
		end
	end

	// The front decides, per item, whether it starts a message and whether
	// its word is full, partial or empty, and masks partial words.
	mm64_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.last           (last),
		.message_length (message_length),
		.full           (full),
		.push           (push),
		.push_op        (push_op)
	);

	mm64_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (empty)
	);

	// The back walks each item through seeding, word mixing, the hash
	// multiply and finalization, and holds the result in an output register
	// so that it can take the next item while a hash waits to be taken.
	mm64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop_op     (pop_op),
		.pop        (pop),
		.hash_seed  (seed_q),
		.mul_go     (mul_go),
		.mul_a      (mul_a),
		.mul_busy   (mul_busy),
		.mul_done   (mul_done),
		.mul_prod   (mul_prod),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	mm64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_prod)
	);

endmodule

`default_nettype wire

[tb/murmur64a_hash_check.sv]
`default_nettype none

// Watches both item channels and the register port, keeps its own copy of the
// hash state, and checks every finished hash against the one it worked out.
module murmur64a_hash_check import mm64_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [63:0]           pwdata,
	input  wire logic [63:0]           prdata,
	input  wire logic                  pready,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [63:0]           data_word,
	input  wire logic [3:0]            byte_count,
	input  wire logic                  last,
	input  wire logic [31:0]           message_length,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [63:0]           hash_value,
	output int                         errors,
	output int                         pending
);

	localparam logic [63:0]           MURMUR_M   = 64'hc6a4a7935bd1e995;
	localparam int                    MURMUR_R   = 47;
	localparam logic [3:0]            WORD_BYTES = 4'd8;
	localparam logic [REG_ADDR_W-1:0] SEED_ADDR  = {REG_IDX_HASH_SEED, 3'b000};

	logic [63:0] seed;
	logic [63:0] running;
	logic        mid_message;
	logic [63:0] h;
	logic [63:0] lane_mask;
	logic [63:0] want;
	logic [3:0]  lanes;
	logic [63:0] expected_hashes[$];
	int          mismatches;

	function automatic logic [63:0] scramble_word(input logic [63:0] k);
		logic [63:0] t;
		t = k * MURMUR_M;
		t = t ^ (t >> MURMUR_R);
		return t * MURMUR_M;
	endfunction

	function automatic logic [63:0] finish_hash(input logic [63:0] x);
		logic [63:0] t;
		t = x ^ (x >> MURMUR_R);
		t = t * MURMUR_M;
		return t ^ (t >> MURMUR_R);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed = '0;
			running = '0;
			mid_message = 1'b0;
			expected_hashes.delete();
			mismatches = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pready && paddr == SEED_ADDR) begin
				if (pwrite) begin
					seed = pwdata;
				end else if (prdata !== seed) begin
					$display("%0t: seed readback, expected %h, got %h", $time, seed, prdata);
					mismatches++;
				end
			end

			// Results first, so that a hash cannot be matched by an item taken
			// at the same edge.
			if (out_valid && !out_stall) begin
				if (expected_hashes.size() == 0) begin
					$display("%0t: hash with none expected, expected none, got %h",
						$time, hash_value);
					mismatches++;
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want) begin
						$display("%0t: hash_value, expected %h, got %h",
							$time, want, hash_value);
						mismatches++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				lanes = (byte_count > WORD_BYTES) ? WORD_BYTES : byte_count;
				h = mid_message ? running : seed ^ ({32'd0, message_length} * MURMUR_M);
				if (lanes == WORD_BYTES) begin
					h = (h ^ scramble_word(data_word)) * MURMUR_M;
				end else if (lanes != 4'd0) begin
					lane_mask = (64'd1 << {lanes, 3'b000}) - 64'd1;
					h = (h ^ (data_word & lane_mask)) * MURMUR_M;
				end
				if (last) begin
					expected_hashes.push_back(finish_hash(h));
					running = '0;
					mid_message = 1'b0;
				end else begin
					running = h;
					mid_message = 1'b1;
				end
			end

			errors <= mismatches;
			pending <= expected_hashes.size();
		end
	end

endmodule

`default_nettype wire

[tb/murmur64a_hash_stream_core_test.sv]
`default_nettype none

// Top of the hash core test. This module only makes stimulus and gives the
// verdict; the checker beside the core predicts every hash and compares.
module murmur64a_hash_stream_core_test;
	import mm64_pkg::*;

	// Register address of the seed, and the timing knobs of the run.
	localparam logic [REG_ADDR_W-1:0] SEED_ADDR       = {REG_IDX_HASH_SEED, 3'b000};
	localparam int                    PHASES          = 8;
	localparam int                    PHASE_ITEMS     = 175;
	localparam int                    HOLD_OFF_CYCLES = 500;
	localparam int                    SETTLE_CYCLES   = 40;
	localparam int                    WATCHDOG_LIMIT  = 4000;
	localparam logic [63:0]           ALL_ONES        = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0]           TOP_BIT         = 64'h8000_0000_0000_0000;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  psel           = 1'b0;
	logic                  penable        = 1'b0;
	logic                  pwrite         = 1'b0;
	logic [REG_ADDR_W-1:0] paddr          = '0;
	logic [63:0]           pwdata         = '0;
	logic [63:0]           prdata;
	logic                  pready;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [63:0]           data_word      = '0;
	logic [3:0]            byte_count     = '0;
	logic                  last           = 1'b0;
	logic [31:0]           message_length = '0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic [63:0]           hash_value;

	int errors;
	int pending;
	int items_sent = 0;
	int quiet_cycles = 0;

	// steady turns off all idling on both sides; hold_req asks the receiver
	// for one long hold-off, and the receiver clears it when that is over.
	bit steady   = 1'b0;
	bit hold_req = 1'b0;

	always #4 clk = ~clk;

	murmur64a_hash_stream_core uut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .data_word, .byte_count, .last, .message_length,
		.out_valid, .out_stall, .hash_value
	);

	murmur64a_hash_check checker_i (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .data_word, .byte_count, .last, .message_length,
		.out_valid, .out_stall, .hash_value,
		.errors, .pending
	);

	// Idle lengths: half of the time none, mostly a few cycles, now and then
	// a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// One APB transfer to the seed register: a setup phase, then an access
	// phase held until pready, then the port is released before the task returns
	// so that a following transfer never drives psel twice in one step.
	task automatic seed_access(input logic wr, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= SEED_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one item and holds it until the core takes it. Valid is only
	// lowered when a gap follows, so back-to-back items keep it high.
	task automatic offer_item(input logic [63:0] word, input logic [3:0] count,
			input logic is_last, input logic [31:0] len);
		int gap;
		in_valid <= 1'b1;
		data_word <= word;
		byte_count <= count;
		last <= is_last;
		message_length <= len;
		do @(posedge clk); while (in_stall);
		items_sent++;
		gap = steady ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly well-formed messages: full words, then an optional partial tail,
	// with the true length on the first item and junk lengths on the rest.
	// The others are broken sequences with any byte count, stray last marks
	// and random lengths. Every sequence ends on a last item, so a phase never
	// leaves a message open.
	task automatic send_message();
		int full_words;
		int tail;
		int n;
		int i;
		logic [31:0] len;
		if ($urandom_range(0, 99) < 85) begin
			full_words = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
				: $urandom_range(0, 4);
			tail = $urandom_range(0, 8);
			len = full_words * 8 + tail;
			if (full_words == 0 && tail == 0) begin
				offer_item(rand_word(), 4'd0, 1'b1, 32'd0);
			end else begin
				for (i = 0; i < full_words; i++)
					offer_item(rand_word(), 4'd8, tail == 0 && i == full_words - 1,
						(i == 0) ? len : $urandom);
				if (tail > 0)
					offer_item(rand_word(), tail[3:0], 1'b1,
						(full_words == 0) ? len : $urandom);
			end
		end else begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				offer_item(rand_word(), 4'($urandom_range(0, 15)),
					i == n - 1 || $urandom_range(0, 4) == 0, $urandom);
		end
	endtask

	// Lets the core run dry: every predicted hash must have come out, and then
	// the core settles for SETTLE_CYCLES before anything else happens. The first edge makes
	// sure the checker has already counted the last item taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] phase_seed(input int phase);
		case (phase)
			0: return ALL_ONES;
			1: return TOP_BIT;
			2: return 64'd1;
			3: return 64'd0;
			default: return rand_word();
		endcase
	endfunction

	// Receiver side: random stall runs, none at all in steady phases, and one
	// long hold-off on request while the sender keeps pushing items, which
	// backs the core up until it stalls its input.
	initial begin
		int stall_run;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				stall_run = steady ? 0 : idle_gap();
				if (stall_run > 0) begin
					out_stall <= 1'b1;
					repeat (stall_run) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat (steady ? 1 : $urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// The run ends early if nothing at all moves for too long: no item in, no
	// hash out, no register access.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles <= 0;
			else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int phase;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The seed must read back as zero straight out of reset.
		seed_access(1'b0, 64'd0);

		// Directed messages under the reset seed. An empty message hashes the
		// seed alone, and its data word must not matter.
		offer_item(ALL_ONES, 4'd0, 1'b1, 32'd0);
		// Single-item messages: one full word, then partial words of one and
		// seven bytes whose upper lanes carry ones that must be masked off.
		offer_item(ALL_ONES, 4'd8, 1'b1, 32'd8);
		offer_item(ALL_ONES, 4'd1, 1'b1, 32'd1);
		offer_item(ALL_ONES, 4'd7, 1'b1, 32'd7);
		// A length far from the bytes sent is used as given.
		offer_item(64'd0, 4'd8, 1'b1, 32'hffff_ffff);
		// A byte count above eight acts as a full word, a zero count in the
		// middle mixes nothing, a short word before the end is mixed as a
		// partial word, and the length field of later items is ignored.
		offer_item(64'h0123_4567_89ab_cdef, 4'd15, 1'b0, 32'd20);
		offer_item(ALL_ONES, 4'd0, 1'b0, 32'hffff_ffff);
		offer_item(64'hfedc_ba98_7654_3210, 4'd5, 1'b0, 32'hdead_beef);
		offer_item(ALL_ONES, 4'd8, 1'b1, 32'd0);
		// A first item with no bytes still seeds the hash.
		offer_item(ALL_ONES, 4'd0, 1'b0, 32'd16);
		offer_item(TOP_BIT, 4'd9, 1'b0, 32'h5555_aaaa);
		offer_item(64'd1, 4'd4, 1'b1, 32'haaaa_5555);
		// A last item with no bytes still finalizes.
		offer_item(64'h8000_0000_0000_0001, 4'd8, 1'b0, 32'd16);
		offer_item(64'h7fff_ffff_ffff_fffe, 4'd12, 1'b0, 32'd3);
		offer_item(ALL_ONES, 4'd0, 1'b1, 32'd7);
		// Partial words of every other size.
		offer_item(ALL_ONES, 4'd2, 1'b1, 32'd2);
		offer_item(ALL_ONES, 4'd3, 1'b1, 32'd3);
		offer_item(ALL_ONES, 4'd6, 1'b1, 32'd6);
		offer_item(64'h00ff_00ff_00ff_00ff, 4'd10, 1'b0, 32'd12);
		offer_item(ALL_ONES, 4'd4, 1'b1, 32'd12);
		drain();

		// Random phases, each under its own seed, written and read back while
		// the core is idle. Two phases run with no idling at all, and one of them
		// also carries the long receiver hold-off.
		for (phase = 0; phase < PHASES; phase++) begin
			seed_access(1'b1, phase_seed(phase));
			seed_access(1'b0, 64'd0);
			steady = (phase == 2 || phase == 5);
			if (phase == 5)
				hold_req = 1'b1;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				send_message();
			drain();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
